[rtl/core/copy_ring_sync_range_resolver_defines.svh]
// assertion macros for the copy ring sync range resolver
`ifndef COPY_RING_SYNC_RANGE_RESOLVER_DEFINES_SVH
`define COPY_RING_SYNC_RANGE_RESOLVER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CRSRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CRSRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/crsrr_pkg.sv]
// types and constants shared by the copy ring sync range resolver
package crsrr_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int MAX_SEGS    = MAX_RESULTS - 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_RETIRE = 2'd1;
    localparam logic [1:0] OP_SYNC   = 2'd2;

    localparam logic [1:0] KIND_RECV = 2'd0;

    typedef enum logic [2:0] {
        STS_PUSHED  = 3'd0,
        STS_FULL    = 3'd1,
        STS_RETIRED = 3'd2,
        STS_EMPTY   = 3'd3,
        STS_SEGMENT = 3'd4,
        STS_DONE    = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [47:0] dest_addr;
        logic [31:0] length;
        logic [31:0] src_page;
        logic [31:0] src_offset;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] seg_dest;
        logic [31:0] seg_page;
        logic [31:0] seg_src_offset;
        logic [31:0] seg_length;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] dest;
        logic [31:0] len;
        logic [31:0] page;
        logic [31:0] offset;
    } ring_entry_t;

endpackage

[rtl/core/crsrr_ram.sv]
// generic single-port-write ram with registered read
module crsrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/copy_ring_sync_range_resolver.sv]
// copy ring sync range resolver top level: descriptor ring and sync walker
//
// request channel (req, req_valid, req_stall) carries one operation per
// transaction: push a descriptor, retire the oldest one, or sync a range.
// response channel (rsp, rsp_valid, rsp_stall) returns the results; the
// last result of each request has last set. op 3 gives no result.
// push and retire: result is in the output register in the cycle after the
// transaction, one request per cycle while the receiver keeps up.
// sync: the walker reads one ring entry per cycle from the descriptor ram
// (registered read) while nothing stalls; req_stall stays high for the whole sync.
// each emitted segment or done waits in the output register; while the
// receiver stalls a full output register the walk holds before emitting
// its next segment or done.
// reset clears the ring pointers (empty ring) and the output valid; ring
// contents are not cleared and need no clearing pass.
module copy_ring_sync_range_resolver #(
    parameter int RING_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  crsrr_pkg::req_t  req,
    input  logic             req_valid,
    output logic             req_stall,
    output crsrr_pkg::rsp_t  rsp,
    output logic             rsp_valid,
    input  logic             rsp_stall
);

`include "copy_ring_sync_range_resolver_defines.svh"

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int ENT_W = $bits(crsrr_pkg::ring_entry_t);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [PTR_W-1:0]            head_reg, head_next;
    logic [PTR_W-1:0]            tail_reg, tail_next;
    logic [PTR_W-1:0]            idx_reg, idx_next;
    logic [crsrr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [48:0]                 start_reg, start_next;
    logic [48:0]                 end_reg, end_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    crsrr_pkg::rsp_t             rsp_reg, rsp_next;

    logic                        out_free;
    logic                        req_acc;
    logic                        ram_wr;
    logic [ENT_W-1:0]            ram_rd_data;
    crsrr_pkg::ring_entry_t      wr_ent;
    crsrr_pkg::ring_entry_t      ent;
    logic [48:0]                 ent_start;
    logic [48:0]                 ent_end;
    logic                        cov_start;
    logic                        cov_end;
    logic                        past_start;
    logic                        walk_end;
    logic [31:0]                 seg_off;

    function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] i);
        next_idx = (i == LAST_IDX) ? '0 : i + PTR_W'(1);
    endfunction

    function automatic crsrr_pkg::rsp_t status_rsp(input crsrr_pkg::status_t s);
        crsrr_pkg::rsp_t r;
        r        = '0;
        r.status = s;
        r.last   = 1'b1;
        status_rsp = r;
    endfunction

    // output register is free when empty or being taken this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE) || !out_free;
    assign req_acc   = req_valid && !req_stall;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // descriptor written at head on a push that fits
    assign wr_ent.kind   = req.kind;
    assign wr_ent.dest   = req.dest_addr;
    assign wr_ent.len    = req.length;
    assign wr_ent.page   = req.src_page;
    assign wr_ent.offset = req.src_offset;
    assign ram_wr = req_acc && (req.op == crsrr_pkg::OP_PUSH)
                    && (next_idx(head_reg) != tail_reg);

    // read address follows the next walk index, so data for idx_reg is ready
    crsrr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (head_reg),
        .wr_data (wr_ent),
        .rd_addr (idx_next),
        .rd_data (ram_rd_data)
    );

    // shared range compare unit for the entry under the walker
    assign ent        = crsrr_pkg::ring_entry_t'(ram_rd_data);
    assign ent_start  = {1'b0, ent.dest};
    assign ent_end    = ent_start + 49'(ent.len);
    assign cov_start  = ent_start <= start_reg;
    assign cov_end    = ent_end >= end_reg;
    assign past_start = start_reg < ent_end;
    assign seg_off    = ent.offset + (start_reg[31:0] - ent.dest[31:0]);
    assign walk_end   = (idx_reg == head_reg)
                        || (cnt_reg == crsrr_pkg::CNT_W'(crsrr_pkg::MAX_SEGS));

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    unique case (req.op)
                        crsrr_pkg::OP_PUSH:
                        begin
                            rsp_valid_next = 1'b1;
                            if (next_idx(head_reg) == tail_reg)
                            begin
                                rsp_next = status_rsp(crsrr_pkg::STS_FULL);
                            end
                            else
                            begin
                                rsp_next  = status_rsp(crsrr_pkg::STS_PUSHED);
                                head_next = next_idx(head_reg);
                            end
                        end
                        crsrr_pkg::OP_RETIRE:
                        begin
                            rsp_valid_next = 1'b1;
                            if (head_reg == tail_reg)
                            begin
                                rsp_next = status_rsp(crsrr_pkg::STS_EMPTY);
                            end
                            else
                            begin
                                rsp_next  = status_rsp(crsrr_pkg::STS_RETIRED);
                                tail_next = next_idx(tail_reg);
                            end
                        end
                        crsrr_pkg::OP_SYNC:
                        begin
                            idx_next   = tail_reg;
                            cnt_next   = '0;
                            start_next = {1'b0, req.dest_addr};
                            end_next   = {1'b0, req.dest_addr} + 49'(req.length);
                            state_next = ST_WALK;
                        end
                        default:
                        begin
                            // unused op: no result
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    if (out_free)
                    begin
                        rsp_next       = status_rsp(crsrr_pkg::STS_DONE);
                        rsp_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if ((ent.kind == crsrr_pkg::KIND_RECV) && cov_start
                         && (cov_end || past_start))
                begin
                    if (out_free)
                    begin
                        rsp_next.status         = crsrr_pkg::STS_SEGMENT;
                        rsp_next.seg_dest       = start_reg[47:0];
                        rsp_next.seg_page       = ent.page;
                        rsp_next.seg_src_offset = seg_off;
                        rsp_next.last           = 1'b0;
                        rsp_valid_next          = 1'b1;
                        cnt_next                = cnt_reg + crsrr_pkg::CNT_W'(1);
                        if (cov_end)
                        begin
                            rsp_next.seg_length = 32'(end_reg - start_reg);
                            state_next          = ST_DONE;
                        end
                        else
                        begin
                            rsp_next.seg_length = 32'(ent_end - start_reg);
                            start_next          = ent_end;
                            idx_next            = next_idx(idx_reg);
                        end
                    end
                end
                else
                begin
                    idx_next = next_idx(idx_reg);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_next       = status_rsp(crsrr_pkg::STS_DONE);
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        rsp_reg   <= rsp_next;
    end

    `CRSRR_ASSERT_NEXT(a_sync_starts_walk, clk, rst_n,
        req_acc && (req.op == crsrr_pkg::OP_SYNC), state_reg == ST_WALK,
        "sync transaction did not start a walk")
    `CRSRR_ASSERT_NEXT(a_ring_stable_in_walk, clk, rst_n,
        state_reg == ST_WALK, $stable(head_reg) && $stable(tail_reg),
        "ring pointers moved during a walk")
    `CRSRR_ASSERT_NOW(a_seg_cap, clk, rst_n,
        state_reg != ST_IDLE,
        cnt_reg <= crsrr_pkg::CNT_W'(crsrr_pkg::MAX_SEGS),
        "segment count passed its cap")
    `CRSRR_ASSERT_NOW(a_seg_not_last, clk, rst_n,
        rsp_valid_reg && (rsp_reg.status == crsrr_pkg::STS_SEGMENT),
        !rsp_reg.last && (state_reg != ST_IDLE),
        "segment marked last or emitted outside a walk")

endmodule
